// ----- rtl/bpsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsm_pkg
// Shared types, widths and constants of the block-wise PSNR/SNR meter.
// ----------------------------------------------------------------------------
package bpsm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int SMP_W   = 16;
  localparam int SQ_W    = 2 * SMP_W;
  localparam int SUM_W   = 63;
  localparam int BLK_W   = 25;
  localparam int BNUM_W  = 20;
  localparam int CNT_O_W = 32;
  localparam int MSE_W   = 40;
  localparam int RMSE_W  = 24;
  localparam int DB_W    = 17;
  localparam int PEAK_W  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam int LOG_FRAC = 24;
  localparam int LOG_W    = 6 + LOG_FRAC;
  localparam int COEF_W   = 30;
  localparam logic [COEF_W-1:0] DB_COEF = 30'd808071242;

  localparam logic [PEAK_W-1:0] PEAK_RST = 16'd255;
  localparam logic [BLK_W-1:0]  BLEN_RST = 25'd152064;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEAK = 2'd0,
    CFG_BLEN = 2'd1,
    CFG_WIDE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LOG_EE  = 2'd0,
    LOG_ER  = 2'd1,
    LOG_P2  = 2'd2,
    LOG_CNT = 2'd3
  } log_sel_t;

  typedef enum logic {
    DB_SNR  = 1'b0,
    DB_PSNR = 1'b1
  } db_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_ENDB, S_TOT, S_RUN, S_DIV, S_SQRT, S_LOG, S_DB, S_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic     load_smp;
    logic     acc;
    logic     snap_blk;
    logic     snap_tot;
    logic     div_start;
    logic     sqrt_start;
    logic     log_start;
    log_sel_t log_sel;
    logic     db_start;
    db_sel_t  db_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic close;
    logic blk_nonempty;
    logic div_done;
    logic sqrt_done;
    logic log_done;
    logic db_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/bpsm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsm_ctrl
// Sequencer: takes items, closes blocks and steps the report units in turn.
// ----------------------------------------------------------------------------
module bpsm_ctrl import bpsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stream_end,
  output logic     in_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  ctrl_state_t state_r, state_nxt;
  log_sel_t    lsel_r, lsel_nxt;
  db_sel_t     dsel_r, dsel_nxt;
  logic        pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lsel_r  <= LOG_EE;
      dsel_r  <= DB_SNR;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lsel_r  <= lsel_nxt;
      dsel_r  <= dsel_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lsel_nxt  = lsel_r;
    dsel_nxt  = dsel_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_stream_end) begin
            state_nxt = S_ENDB;
          end else begin
            cmd.load_smp = 1'b1;
            state_nxt    = S_ACC;
          end
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = stat.close ? S_RUN : S_IDLE;
      end
      S_ENDB: begin
        if (stat.blk_nonempty) begin
          cmd.snap_blk = 1'b1;
          pend_nxt     = 1'b1;
        end else begin
          cmd.snap_tot = 1'b1;
          pend_nxt     = 1'b0;
        end
        state_nxt = S_RUN;
      end
      S_TOT: begin
        cmd.snap_tot = 1'b1;
        pend_nxt     = 1'b0;
        state_nxt    = S_RUN;
      end
      S_RUN: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          cmd.log_start = 1'b1;
          cmd.log_sel   = LOG_EE;
          lsel_nxt      = LOG_EE;
          state_nxt     = S_LOG;
        end
      end
      S_LOG: begin
        if (stat.log_done) begin
          if (lsel_r == LOG_CNT) begin
            cmd.db_start = 1'b1;
            cmd.db_sel   = DB_SNR;
            dsel_nxt     = DB_SNR;
            state_nxt    = S_DB;
          end else begin
            lsel_nxt      = log_sel_t'(lsel_r + 2'd1);
            cmd.log_start = 1'b1;
            cmd.log_sel   = lsel_nxt;
          end
        end
      end
      S_DB: begin
        if (stat.db_done) begin
          if (dsel_r == DB_PSNR) begin
            state_nxt = S_LOAD;
          end else begin
            cmd.db_start = 1'b1;
            cmd.db_sel   = DB_PSNR;
            dsel_nxt     = DB_PSNR;
          end
        end
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = pend_r ? S_TOT : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/bpsm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsm_dp
// Datapath: config registers, accumulators, report snapshot, serial divider,
// square root, log2 and dB units, and the result register.
// ----------------------------------------------------------------------------
module bpsm_dp import bpsm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [SMP_W-1:0]             in_sample_a,
  input  logic [SMP_W-1:0]             in_sample_b,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic                         out_is_total,
  output logic [BNUM_W-1:0]            out_block_number,
  output logic [CNT_O_W-1:0]           out_sample_count,
  output logic [SUM_W-1:0]             out_energy_ref,
  output logic [SUM_W-1:0]             out_energy_test,
  output logic [SUM_W-1:0]             out_energy_err,
  output logic [MSE_W-1:0]             out_mse_q8,
  output logic [RMSE_W-1:0]            out_rmse_q8,
  output logic signed [DB_W-1:0]       out_snr_db_q8,
  output logic signed [DB_W-1:0]       out_psnr_db_q8,
  output logic                         out_last_of_run
);

  localparam int RC_W   = (COUNT_BITS > BLK_W + 1) ? COUNT_BITS : BLK_W + 1;
  localparam int QW     = SUM_W + 2 * FRAC_BITS;
  localparam int DV_CW  = $clog2(QW + 1);
  localparam int LK_W   = $clog2(LOG_FRAC + 1);
  localparam int DB_SH  = 52 - FRAC_BITS;
  localparam int PROD_W = 32 + COEF_W;
  localparam logic [SMP_W-1:0] WIDE_MASK = SMP_W'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam logic signed [DB_W-1:0] DB_MAX_V  = 17'sd65535;
  localparam logic signed [DB_W-1:0] DB_MIN_V  = DB_W'(-65536);
  localparam logic signed [DB_W-1:0] SENTINEL  = DB_W'(32'd1 << FRAC_BITS);

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] x,
                                                input logic [SQ_W-1:0] y);
    logic [SUM_W:0] s;
    s = {1'b0, x} + {{(SUM_W + 1 - SQ_W){1'b0}}, y};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // configuration
  logic [PEAK_W-1:0] peak_r;
  logic [BLK_W-1:0]  blen_r;
  logic              wide_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= PEAK_RST;
      blen_r <= BLEN_RST;
      wide_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PEAK: peak_r <= cfg_data[PEAK_W-1:0];
        CFG_BLEN: blen_r <= cfg_data[BLK_W-1:0];
        CFG_WIDE: wide_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // squares of the masked samples
  logic [SMP_W-1:0] a_m, b_m, d_m;
  logic [SQ_W-1:0]  sq_a_r, sq_b_r, sq_d_r;

  always_comb begin
    a_m = in_sample_a & (wide_r ? WIDE_MASK : SMP_W'(8'hFF));
    b_m = in_sample_b & (wide_r ? WIDE_MASK : SMP_W'(8'hFF));
    d_m = (a_m > b_m) ? a_m - b_m : b_m - a_m;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_smp) begin
      sq_a_r <= a_m * a_m;
      sq_b_r <= b_m * b_m;
      sq_d_r <= d_m * d_m;
    end
  end

  // accumulators
  logic [SUM_W-1:0]      tot_er_r, tot_et_r, tot_ee_r;
  logic [SUM_W-1:0]      blk_er_r, blk_et_r, blk_ee_r;
  logic [SUM_W-1:0]      blk_er_nxt, blk_et_nxt, blk_ee_nxt;
  logic [COUNT_BITS-1:0] tot_n_r;
  logic [BLK_W-1:0]      blk_n_r, blk_n_nxt, len;
  logic [BNUM_W-1:0]     bnum_r;
  logic                  close;

  always_comb begin
    blk_er_nxt = sat_add(blk_er_r, sq_a_r);
    blk_et_nxt = sat_add(blk_et_r, sq_b_r);
    blk_ee_nxt = sat_add(blk_ee_r, sq_d_r);
    blk_n_nxt  = blk_n_r + BLK_W'(1);
    len        = (blen_r == '0) ? BLK_W'(1) : blen_r;
    close      = (blk_n_nxt >= len) || (blk_n_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.snap_tot) begin
      tot_er_r <= '0;
      tot_et_r <= '0;
      tot_ee_r <= '0;
      tot_n_r  <= '0;
      blk_er_r <= '0;
      blk_et_r <= '0;
      blk_ee_r <= '0;
      blk_n_r  <= '0;
      bnum_r   <= '0;
    end else if (cmd.acc) begin
      tot_er_r <= sat_add(tot_er_r, sq_a_r);
      tot_et_r <= sat_add(tot_et_r, sq_b_r);
      tot_ee_r <= sat_add(tot_ee_r, sq_d_r);
      if (tot_n_r != '1) tot_n_r <= tot_n_r + COUNT_BITS'(1);
      if (close) begin
        blk_er_r <= '0;
        blk_et_r <= '0;
        blk_ee_r <= '0;
        blk_n_r  <= '0;
        if (bnum_r != '1) bnum_r <= bnum_r + BNUM_W'(1);
      end else begin
        blk_er_r <= blk_er_nxt;
        blk_et_r <= blk_et_nxt;
        blk_ee_r <= blk_ee_nxt;
        blk_n_r  <= blk_n_nxt;
      end
    end
  end

  // report snapshot
  logic              rep_total_r, rep_last_r;
  logic [BNUM_W-1:0] rep_num_r;
  logic [RC_W-1:0]   rep_cnt_r;
  logic [SUM_W-1:0]  rep_er_r, rep_et_r, rep_ee_r;

  always_ff @(posedge clk) begin
    if (cmd.acc && close) begin
      rep_total_r <= 1'b0;
      rep_last_r  <= 1'b1;
      rep_num_r   <= bnum_r;
      rep_cnt_r   <= (blk_n_nxt == '0) ? RC_W'({1'b1, {BLK_W{1'b0}}}) : RC_W'(blk_n_nxt);
      rep_er_r    <= blk_er_nxt;
      rep_et_r    <= blk_et_nxt;
      rep_ee_r    <= blk_ee_nxt;
    end else if (cmd.snap_blk) begin
      rep_total_r <= 1'b0;
      rep_last_r  <= 1'b0;
      rep_num_r   <= bnum_r;
      rep_cnt_r   <= RC_W'(blk_n_r);
      rep_er_r    <= blk_er_r;
      rep_et_r    <= blk_et_r;
      rep_ee_r    <= blk_ee_r;
    end else if (cmd.snap_tot) begin
      rep_total_r <= 1'b1;
      rep_last_r  <= 1'b1;
      rep_num_r   <= '0;
      rep_cnt_r   <= RC_W'(tot_n_r);
      rep_er_r    <= tot_er_r;
      rep_et_r    <= tot_et_r;
      rep_ee_r    <= tot_ee_r;
    end
  end

  // restoring divider: err * 2^(2F) / count, one quotient bit a cycle
  logic [QW-1:0]    dv_q_r;
  logic [RC_W-1:0]  dv_rem_r;
  logic [DV_CW-1:0] dv_cnt_r;
  logic             dv_done_r;
  logic [RC_W:0]    dv_sh;
  logic [RC_W:0]    dv_diff;
  logic [63:0]      q_sat;
  logic [MSE_W-1:0] mse_sat;

  always_comb begin
    dv_sh   = {dv_rem_r, dv_q_r[QW-1]};
    dv_diff = dv_sh - {1'b0, rep_cnt_r};
    q_sat   = (|dv_q_r[QW-1:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : dv_q_r[63:0];
    mse_sat = (|dv_q_r[QW-1:FRAC_BITS+MSE_W]) ? {MSE_W{1'b1}}
            : dv_q_r[FRAC_BITS+MSE_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_cnt_r  <= '0;
      dv_done_r <= 1'b0;
    end else begin
      dv_done_r <= 1'b0;
      if (cmd.div_start) begin
        dv_cnt_r <= DV_CW'(QW);
      end else if (dv_cnt_r != '0) begin
        dv_cnt_r <= dv_cnt_r - DV_CW'(1);
        if (dv_cnt_r == DV_CW'(1)) dv_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_q_r   <= {rep_ee_r, {(2 * FRAC_BITS){1'b0}}};
      dv_rem_r <= '0;
    end else if (dv_cnt_r != '0) begin
      if (dv_sh >= {1'b0, rep_cnt_r}) begin
        dv_rem_r <= dv_diff[RC_W-1:0];
        dv_q_r   <= {dv_q_r[QW-2:0], 1'b1};
      end else begin
        dv_rem_r <= dv_sh[RC_W-1:0];
        dv_q_r   <= {dv_q_r[QW-2:0], 1'b0};
      end
    end
  end

  // bit-pair square root
  logic [63:0] sq_x_r, sq_res_r, sq_one_r, sq_t;
  logic        sq_done_r;

  assign sq_t = sq_res_r + sq_one_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_one_r  <= '0;
      sq_done_r <= 1'b0;
    end else begin
      sq_done_r <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_one_r <= 64'h4000_0000_0000_0000;
      end else if (sq_one_r != '0) begin
        sq_one_r <= sq_one_r >> 2;
        if (sq_one_r == 64'd1) sq_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_x_r   <= q_sat;
      sq_res_r <= '0;
    end else if (sq_one_r != '0) begin
      if (sq_x_r >= sq_t) begin
        sq_x_r   <= sq_x_r - sq_t;
        sq_res_r <= (sq_res_r >> 1) + sq_one_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
    end
  end

  // log2 in Q24: normalize a bit a cycle, then 24 truncating squarings
  logic [63:0]         lg_x_r, lg_in;
  logic [5:0]          lg_sh_r;
  logic                lg_norm_r, lg_done_r;
  logic [LK_W-1:0]     lg_k_r;
  logic [31:0]         lg_m_r;
  logic [LOG_FRAC-1:0] lg_frac_r, lg_frac_nxt;
  log_sel_t            lg_sel_r;
  logic [63:0]         lg_p;
  logic [32:0]         lg_s;
  logic [LOG_W-1:0]    l_ee_r, l_er_r, l_p2_r, l_cnt_r, lg_res;

  always_comb begin
    case (cmd.log_sel)
      LOG_EE:  lg_in = {1'b0, rep_ee_r};
      LOG_ER:  lg_in = {1'b0, rep_er_r};
      LOG_P2:  lg_in = {32'd0, 32'(peak_r) * 32'(peak_r)};
      LOG_CNT: lg_in = 64'(rep_cnt_r);
      default: lg_in = '0;
    endcase
    lg_p        = lg_m_r * lg_m_r;
    lg_s        = lg_p[63:31];
    lg_frac_nxt = {lg_frac_r[LOG_FRAC-2:0], lg_s[32]};
    lg_res      = {6'(6'd63 - lg_sh_r), lg_frac_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_norm_r <= 1'b0;
      lg_k_r    <= '0;
      lg_done_r <= 1'b0;
    end else begin
      lg_done_r <= 1'b0;
      if (cmd.log_start) begin
        lg_norm_r <= 1'b1;
      end else if (lg_norm_r) begin
        if (lg_x_r[63] || lg_sh_r == 6'd63) begin
          lg_norm_r <= 1'b0;
          lg_k_r    <= LK_W'(LOG_FRAC);
        end
      end else if (lg_k_r != '0) begin
        lg_k_r <= lg_k_r - LK_W'(1);
        if (lg_k_r == LK_W'(1)) lg_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.log_start) begin
      lg_x_r   <= lg_in;
      lg_sh_r  <= '0;
      lg_sel_r <= cmd.log_sel;
    end else if (lg_norm_r) begin
      if (lg_x_r[63] || lg_sh_r == 6'd63) begin
        lg_m_r    <= lg_x_r[63:32];
        lg_frac_r <= '0;
      end else begin
        lg_x_r  <= lg_x_r << 1;
        lg_sh_r <= lg_sh_r + 6'd1;
      end
    end else if (lg_k_r != '0) begin
      lg_m_r    <= lg_s[32] ? lg_s[32:1] : lg_s[31:0];
      lg_frac_r <= lg_frac_nxt;
      if (lg_k_r == LK_W'(1)) begin
        case (lg_sel_r)
          LOG_EE:  l_ee_r  <= lg_res;
          LOG_ER:  l_er_r  <= lg_res;
          LOG_P2:  l_p2_r  <= lg_res;
          LOG_CNT: l_cnt_r <= lg_res;
          default: ;
        endcase
      end
    end
  end

  // dB scaling: multiply, then round and saturate
  logic signed [31:0]       db_d;
  logic [31:0]              db_mag;
  logic [PROD_W-1:0]        db_prod_r;
  logic                     db_neg_r, db_s1_r, db_done_r;
  db_sel_t                  db_sel_r;
  logic [PROD_W:0]          db_rnd;
  logic [PROD_W:0]          db_v;
  logic signed [DB_W-1:0]   db_res;
  logic signed [DB_W-1:0]   snr_r, psnr_r;

  always_comb begin
    if (cmd.db_sel == DB_PSNR) begin
      db_d = $signed({2'b0, l_p2_r}) + $signed({2'b0, l_cnt_r}) - $signed({2'b0, l_ee_r});
    end else begin
      db_d = $signed({2'b0, l_er_r}) - $signed({2'b0, l_ee_r});
    end
    db_mag = db_d[31] ? 32'(-db_d) : 32'(db_d);
    db_rnd = {1'b0, db_prod_r} + ((PROD_W + 1)'(1) << (DB_SH - 1));
    db_v   = db_rnd >> DB_SH;
    if (db_neg_r) begin
      db_res = (db_v > (PROD_W + 1)'(65536)) ? DB_MIN_V : DB_W'(DB_W'(0) - db_v[DB_W-1:0]);
    end else begin
      db_res = (db_v > (PROD_W + 1)'(65535)) ? DB_MAX_V : DB_W'(db_v[DB_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_s1_r   <= 1'b0;
      db_done_r <= 1'b0;
    end else begin
      db_s1_r   <= cmd.db_start;
      db_done_r <= db_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.db_start) begin
      db_prod_r <= db_mag * DB_COEF;
      db_neg_r  <= db_d[31];
      db_sel_r  <= cmd.db_sel;
    end
    if (db_s1_r) begin
      if (db_sel_r == DB_PSNR) psnr_r <= db_res;
      else snr_r <= db_res;
    end
  end

  // result register
  logic ee_zero;
  assign ee_zero = (rep_ee_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_is_total     <= rep_total_r;
      out_block_number <= rep_num_r;
      out_sample_count <= (rep_cnt_r > RC_W'(32'hFFFF_FFFF)) ? {CNT_O_W{1'b1}}
                        : CNT_O_W'(rep_cnt_r);
      out_energy_ref   <= rep_er_r;
      out_energy_test  <= rep_et_r;
      out_energy_err   <= rep_ee_r;
      out_last_of_run  <= rep_last_r;
      if (ee_zero) begin
        out_mse_q8     <= '0;
        out_rmse_q8    <= '0;
        out_snr_db_q8  <= SENTINEL;
        out_psnr_db_q8 <= SENTINEL;
      end else begin
        out_mse_q8     <= mse_sat;
        out_rmse_q8    <= (|sq_res_r[63:RMSE_W]) ? {RMSE_W{1'b1}} : sq_res_r[RMSE_W-1:0];
        out_snr_db_q8  <= (rep_er_r == '0) ? DB_MIN_V : snr_r;
        out_psnr_db_q8 <= (peak_r == '0 || rep_cnt_r == '0) ? DB_MIN_V : psnr_r;
      end
    end
  end

  always_comb begin
    stat.close        = close;
    stat.blk_nonempty = (blk_n_r != '0);
    stat.div_done     = dv_done_r;
    stat.sqrt_done    = sq_done_r;
    stat.log_done     = lg_done_r;
    stat.db_done      = db_done_r;
    stat.out_free     = !out_valid || !out_stall;
  end

endmodule

// ----- rtl/blockwise_psnr_snr_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blockwise_psnr_snr_meter
// Block and whole-stream energy, MSE, RMSE, SNR and PSNR measurement.
// ----------------------------------------------------------------------------
// A sample pair that does not close a block is taken in S_IDLE and summed in S_ACC;
// the input stalls until S_IDLE. A report runs the divider, the square root, four
// log2 passes (normalize, then 24 squarings) and the SNR and PSNR dB steps in turn.
// An end item with a partial block runs two reports back to back.
// Synchronous active-low reset clears all sums and counts; registers go to
// peak 255, block length 152064, 8-bit samples.
module blockwise_psnr_snr_meter import bpsm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SMP_W-1:0]       in_sample_a,
  input  logic [SMP_W-1:0]       in_sample_b,
  input  logic                   in_stream_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_is_total,
  output logic [BNUM_W-1:0]      out_block_number,
  output logic [CNT_O_W-1:0]     out_sample_count,
  output logic [SUM_W-1:0]       out_energy_ref,
  output logic [SUM_W-1:0]       out_energy_test,
  output logic [SUM_W-1:0]       out_energy_err,
  output logic [MSE_W-1:0]       out_mse_q8,
  output logic [RMSE_W-1:0]      out_rmse_q8,
  output logic signed [DB_W-1:0] out_snr_db_q8,
  output logic signed [DB_W-1:0] out_psnr_db_q8,
  output logic                   out_last_of_run
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bpsm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stream_end (in_stream_end),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .stat          (stat)
  );

  bpsm_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample_a      (in_sample_a),
    .in_sample_b      (in_sample_b),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_is_total     (out_is_total),
    .out_block_number (out_block_number),
    .out_sample_count (out_sample_count),
    .out_energy_ref   (out_energy_ref),
    .out_energy_test  (out_energy_test),
    .out_energy_err   (out_energy_err),
    .out_mse_q8       (out_mse_q8),
    .out_rmse_q8      (out_rmse_q8),
    .out_snr_db_q8    (out_snr_db_q8),
    .out_psnr_db_q8   (out_psnr_db_q8),
    .out_last_of_run  (out_last_of_run)
  );

  // a result is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken transaction");

  // the block is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in work");

  // accumulation always follows a sample load
  a_acc_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> $past(cmd.load_smp))
    else $error("accumulate without a loaded sample");

endmodule

// ----- tb/blockwise_psnr_snr_meter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blockwise_psnr_snr_meter_test
// Streams sample pairs and end markers through the meter and checks every
// block and whole-stream report against a cycle-free model of the sums, MSE,
// RMSE and fixed-point SNR/PSNR, over several register settings and idling
// patterns.
// ----------------------------------------------------------------------------
module blockwise_psnr_snr_meter_test;
  import bpsm_pkg::*;

  localparam logic [63:0] SUM_SAT   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] COUNT_SAT = 64'hFFFF_FFFF;
  localparam int          FRAC      = 8;
  localparam longint      LIMIT     = 4000000;
  localparam int          SETTLE    = 600;

  typedef struct {
    logic              is_total;
    logic [BNUM_W-1:0] block_number;
    logic [CNT_O_W-1:0] sample_count;
    logic [SUM_W-1:0]  energy_ref;
    logic [SUM_W-1:0]  energy_test;
    logic [SUM_W-1:0]  energy_err;
    logic [MSE_W-1:0]  mse;
    logic [RMSE_W-1:0] rmse;
    logic [DB_W-1:0]   snr;
    logic [DB_W-1:0]   psnr;
    logic              last;
  } report_t;

  typedef struct {
    logic [SMP_W-1:0] a;
    logic [SMP_W-1:0] b;
    logic             stream_end;
    logic             empty_total;
  } stim_row_t;

  typedef struct {
    logic [PEAK_W-1:0] peak;
    logic [BLK_W-1:0]  blen;
    logic              wide;
    int                items;
  } setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SMP_W-1:0] in_sample_a = '0;
  logic [SMP_W-1:0] in_sample_b = '0;
  logic in_stream_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_is_total;
  logic [BNUM_W-1:0] out_block_number;
  logic [CNT_O_W-1:0] out_sample_count;
  logic [SUM_W-1:0] out_energy_ref, out_energy_test, out_energy_err;
  logic [MSE_W-1:0] out_mse_q8;
  logic [RMSE_W-1:0] out_rmse_q8;
  logic signed [DB_W-1:0] out_snr_db_q8, out_psnr_db_q8;
  logic out_last_of_run;

  blockwise_psnr_snr_meter dut (.*);

  always #10 clk = ~clk;

  // model state
  logic [63:0] m_peak, m_blen;
  logic        m_wide;
  logic [63:0] tot_ref, tot_test, tot_err, tot_cnt;
  logic [63:0] blk_ref, blk_test, blk_err, blk_cnt, blk_num;

  report_t pending_reports[$];
  int errors = 0;
  int reports_seen = 0;
  int items_sent = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_left = 0;
  longint cycles = 0;

  function automatic logic [63:0] sum_sat(logic [63:0] x, logic [63:0] y);
    logic [64:0] r;
    r = {1'b0, x} + {1'b0, y};
    return (r > {1'b0, SUM_SAT}) ? SUM_SAT : r[63:0];
  endfunction

  function automatic logic [63:0] shifted_quotient(logic [63:0] num, int sh, logic [63:0] den);
    logic [63:0] q, r, bitv;
    q = 0;
    r = 0;
    if (den == 0) return '1;
    for (int i = 63 + sh - 1; i >= 0; i--) begin
      bitv = (i >= sh) ? ((num >> (i - sh)) & 64'd1) : 64'd0;
      r = (r << 1) | bitv;
      if (q[63]) return '1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > x) one = one >> 2;
    while (one != 0) begin
      if (x >= res + one) begin
        x = x - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic longint log2_q24(logic [63:0] x);
    int e;
    logic [63:0] m, frac;
    e = 63;
    frac = 0;
    while (x[e] == 1'b0) e--;
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    for (int k = 0; k < 24; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return longint'((64'(e) << 24) | frac);
  endfunction

  function automatic longint db_q8(longint d);
    logic [63:0] mag, v;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    v = (mag * 64'd808071242 + (64'd1 << 43)) >> 44;
    if (d < 0) return (v > 64'd65536) ? -65536 : -longint'(v);
    return (v > 64'd65535) ? 65535 : longint'(v);
  endfunction

  function automatic report_t make_report(logic tot, logic [63:0] num, logic [63:0] cnt,
                                          logic [63:0] er, logic [63:0] et, logic [63:0] ee,
                                          logic last);
    report_t r;
    logic [63:0] mse, rmse, p2;
    longint snr, psnr;
    mse = 0;
    rmse = 0;
    snr = 1 << FRAC;
    psnr = 1 << FRAC;
    if (ee != 0) begin
      p2 = m_peak * m_peak;
      mse = shifted_quotient(ee, FRAC, cnt);
      if (mse > 64'hFF_FFFF_FFFF) mse = 64'hFF_FFFF_FFFF;
      rmse = int_sqrt(shifted_quotient(ee, 2 * FRAC, cnt));
      if (rmse > 64'hFF_FFFF) rmse = 64'hFF_FFFF;
      snr = (er == 0) ? -65536 : db_q8(log2_q24(er) - log2_q24(ee));
      psnr = (p2 == 0 || cnt == 0) ? -65536
           : db_q8(log2_q24(p2) + log2_q24(cnt) - log2_q24(ee));
    end
    r.is_total = tot;
    r.block_number = num[BNUM_W-1:0];
    r.sample_count = (cnt > 64'hFFFF_FFFF) ? '1 : cnt[31:0];
    r.energy_ref = er[62:0];
    r.energy_test = et[62:0];
    r.energy_err = ee[62:0];
    r.mse = mse[MSE_W-1:0];
    r.rmse = rmse[RMSE_W-1:0];
    r.snr = snr[DB_W-1:0];
    r.psnr = psnr[DB_W-1:0];
    r.last = last;
    return r;
  endfunction

  function automatic void clear_stream();
    tot_ref = 0; tot_test = 0; tot_err = 0; tot_cnt = 0;
    blk_ref = 0; blk_test = 0; blk_err = 0; blk_cnt = 0; blk_num = 0;
  endfunction

  // advances the model by one transaction and returns the reports it causes
  function automatic void meter_step(logic [15:0] a_in, logic [15:0] b_in, logic se,
                                     ref report_t outq[$]);
    logic [63:0] a, b, d, len, c;
    if (se) begin
      if (blk_cnt != 0)
        outq.push_back(make_report(1'b0, blk_num, blk_cnt, blk_ref, blk_test, blk_err, 1'b0));
      outq.push_back(make_report(1'b1, 0, tot_cnt, tot_ref, tot_test, tot_err, 1'b1));
      clear_stream();
    end else begin
      a = m_wide ? 64'(a_in) : 64'(a_in[7:0]);
      b = m_wide ? 64'(b_in) : 64'(b_in[7:0]);
      d = (a > b) ? a - b : b - a;
      len = (m_blen == 0) ? 64'd1 : m_blen;
      tot_ref = sum_sat(tot_ref, a * a);
      tot_test = sum_sat(tot_test, b * b);
      tot_err = sum_sat(tot_err, d * d);
      if (tot_cnt < COUNT_SAT) tot_cnt++;
      blk_ref = sum_sat(blk_ref, a * a);
      blk_test = sum_sat(blk_test, b * b);
      blk_err = sum_sat(blk_err, d * d);
      blk_cnt = (blk_cnt + 1) & 64'h1FF_FFFF;
      if (blk_cnt >= len || blk_cnt == 0) begin
        c = (blk_cnt == 0) ? 64'h200_0000 : blk_cnt;
        outq.push_back(make_report(1'b0, blk_num, c, blk_ref, blk_test, blk_err, 1'b1));
        blk_ref = 0; blk_test = 0; blk_err = 0; blk_cnt = 0;
        if (blk_num < 64'hF_FFFF) blk_num++;
      end
    end
  endfunction

  task automatic field_check(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    report_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, total=%0b count=%0d", $time, out_is_total,
                 out_sample_count);
      end else begin
        e = pending_reports.pop_front();
        field_check("is_total", e.is_total, out_is_total);
        field_check("block_number", e.block_number, out_block_number);
        field_check("sample_count", e.sample_count, out_sample_count);
        field_check("energy_ref", e.energy_ref, out_energy_ref);
        field_check("energy_test", e.energy_test, out_energy_test);
        field_check("energy_err", e.energy_err, out_energy_err);
        field_check("mse_q8", e.mse, out_mse_q8);
        field_check("rmse_q8", e.rmse, out_rmse_q8);
        // compare the raw 17-bit codes
        field_check("snr_db_q8", e.snr, $unsigned(out_snr_db_q8));
        field_check("psnr_db_q8", e.psnr, $unsigned(out_psnr_db_q8));
        field_check("last_of_run", e.last, out_last_of_run);
      end
    end
  end

  // receiver back-pressure, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  task automatic reg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_PEAK: m_peak = 64'(value[PEAK_W-1:0]);
      CFG_BLEN: m_blen = 64'(value);
      CFG_WIDE: m_wide = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic [15:0] a, logic [15:0] b, logic se, logic empty_total);
    report_t got[$];
    report_t fixed;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample_a <= a;
    in_sample_b <= b;
    in_stream_end <= se;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    meter_step(a, b, se, got);
    if (empty_total) begin
      // an end marker on an empty stream: all zeros with the zero-error sentinels
      fixed = '{is_total: 1'b1, block_number: '0, sample_count: '0, energy_ref: '0,
                energy_test: '0, energy_err: '0, mse: '0, rmse: '0, snr: 17'd256,
                psnr: 17'd256, last: 1'b1};
      pending_reports.push_back(fixed);
    end else begin
      foreach (got[i]) pending_reports.push_back(got[i]);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_reports.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h00FF;
      default: return 16'($urandom);
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1},
    '{16'h0000, 16'h0000, 1'b0, 1'b0},
    '{16'hFFFF, 16'h0000, 1'b0, 1'b0},
    '{16'h0000, 16'hFFFF, 1'b0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0},
    '{16'h0064, 16'h0064, 1'b0, 1'b0},
    '{16'h0064, 16'h0064, 1'b0, 1'b0},
    '{16'h1234, 16'h5678, 1'b1, 1'b0},
    '{16'h0000, 16'h0000, 1'b1, 1'b1},
    '{16'h0000, 16'h0005, 1'b0, 1'b0},
    '{16'h0000, 16'h0009, 1'b0, 1'b0},
    '{16'h0000, 16'h0000, 1'b1, 1'b0},
    '{16'hFFFF, 16'hFF00, 1'b0, 1'b0},
    '{16'h8000, 16'h7FFF, 1'b0, 1'b0},
    '{16'hAAAA, 16'h5555, 1'b0, 1'b0},
    '{16'h00FF, 16'h0001, 1'b0, 1'b0},
    '{16'h0000, 16'h0000, 1'b1, 1'b0}
  };

  setting_t settings[] = '{
    '{16'd65535, 25'd1,        1'b1, 140},
    '{16'd1,     25'd7,        1'b0, 170},
    '{16'd0,     25'd3,        1'b1, 170},
    '{16'd1000,  25'h1000000,  1'b1, 120},
    '{16'd12345, 25'd0,        1'b1, 140},
    '{16'd255,   25'd10,       1'b0, 180},
    '{16'd65535, 25'd5,        1'b1, 180},
    '{16'd255,   25'd152064,   1'b0, 120}
  };

  initial begin
    logic [15:0] a, b;
    int mode;
    m_peak = 64'(PEAK_RST);
    m_blen = 64'(BLEN_RST);
    m_wide = 1'b0;
    clear_stream();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    reg_write(CFG_BLEN, 25'd4);
    reg_write(CFG_WIDE, 25'd1);
    foreach (directed[i])
      send_item(directed[i].a, directed[i].b, directed[i].stream_end, directed[i].empty_total);
    drain();

    foreach (settings[p]) begin
      reg_write(CFG_PEAK, 25'(settings[p].peak));
      reg_write(CFG_BLEN, settings[p].blen);
      reg_write(CFG_WIDE, 25'(settings[p].wide));
      mode = p % 4;
      in_idle_pct = (mode == 1) ? 61 : (mode == 3) ? 9 : 0;
      out_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 9 : 0;
      // long receiver hold-off so the block backs up into its input
      if (p == 2) hold_left = 4000;
      for (int n = 0; n < settings[p].items; n++) begin
        if ($urandom_range(0, 99) < 4) begin
          send_item(16'($urandom), 16'($urandom), 1'b1, 1'b0);
        end else begin
          a = pick_sample();
          case ($urandom_range(0, 3))
            0: b = a;
            1: b = a ^ 16'($urandom_range(0, 7));
            default: b = pick_sample();
          endcase
          send_item(a, b, 1'b0, 1'b0);
        end
      end
      send_item(16'($urandom), 16'($urandom), 1'b1, 1'b0);
      drain();
    end

    $display("covered %0d transactions in, %0d reports out, over %0d register settings",
             items_sent, reports_seen, settings.size() + 1);
    $display("idling phases: none, sender, receiver, both; one long receiver hold-off");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bpsm_pkg.sv
rtl/bpsm_ctrl.sv
rtl/bpsm_dp.sv
rtl/blockwise_psnr_snr_meter.sv
tb/blockwise_psnr_snr_meter_test.sv
